[sv/fraction_reducer_core_assert.svh]
// Assertion macros used by the checker of the fraction reducer.
`ifndef FRACTION_REDUCER_CORE_ASSERT_SVH
`define FRACTION_REDUCER_CORE_ASSERT_SVH

// Check a property on every rising edge of clk, outside reset.
`define FR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition seen at one edge leads to a result at the next edge.
`define FR_ASSERT_NEXT(label, cond, prop, msg) \
	`FR_ASSERT(label, (cond) |=> (prop), msg)

`endif

[sv/frred_pkg.sv]
package frred_pkg;

	localparam int FIELD_W = 32;

	typedef struct packed {
		logic load;        // capture a new word from the input channel
		logic gcd_en;      // run one binary gcd step
		logic div_init_n;  // start dividing the numerator by the gcd
		logic div_init_d;  // start dividing the denominator by the gcd
		logic div_en;      // run one divider step
		logic save_n;      // keep the finished numerator quotient
		logic out_load;    // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic in_zero;     // incoming numerator and denominator both zero
		logic gcd_done;    // one operand reached zero, gcd is ready
		logic div_last;    // divider is on its final step
	} status_t;

endpackage

[sv/frred_dp.sv]
module frred_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frred_pkg::cmd_t               cmd,
	output frred_pkg::status_t            status,
	input  logic [frred_pkg::FIELD_W-1:0] numerator_in,
	input  logic [frred_pkg::FIELD_W-1:0] denominator_in,
	output logic [frred_pkg::FIELD_W-1:0] numerator_out,
	output logic [frred_pkg::FIELD_W-1:0] denominator_out,
	output logic [frred_pkg::FIELD_W-1:0] gcd_value,
	output logic                          zero_error
);

	localparam int W  = DATA_WIDTH;
	localparam int FW = frred_pkg::FIELD_W;
	localparam int MW = (W > FW) ? W : FW;
	localparam int CW = $clog2(W);

	logic [MW-1:0] num_ext, den_ext;
	logic [W-1:0]  num_w, den_w;

	logic [W-1:0]  a_q, b_q, n_q, d_q, g_q;
	logic [CW-1:0] k_q;
	logic          zero_q;

	logic [W-1:0]  rem_q, quo_q, qn_q;
	logic [CW-1:0] cnt_q;

	logic [W:0]    diff_ab, diff_ba;
	logic [W-1:0]  g_next;

	logic [W:0]    trial;
	logic [W+1:0]  sub;
	logic          take;
	logic [W-1:0]  rem_next, quo_next;

	logic [MW-1:0] qn_ext, qd_ext, g_ext;

	assign num_ext = MW'(numerator_in);
	assign den_ext = MW'(denominator_in);
	assign num_w   = num_ext[W-1:0];
	assign den_w   = den_ext[W-1:0];

	assign status.in_zero  = (num_w == '0) && (den_w == '0);
	assign status.gcd_done = (a_q == '0) || (b_q == '0);
	assign status.div_last = (cnt_q == CW'(W - 1));

	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
	assign g_next  = (a_q | b_q) << k_q;

	// restoring divider: shift in one dividend bit, subtract when it fits
	assign trial    = {rem_q, quo_q[W-1]};
	assign sub      = {1'b0, trial} - {2'b00, g_q};
	assign take     = !sub[W+1];
	assign rem_next = take ? sub[W-1:0] : trial[W-1:0];
	assign quo_next = {quo_q[W-2:0], take};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= num_w;
			b_q    <= den_w;
			n_q    <= num_w;
			d_q    <= den_w;
			k_q    <= '0;
			zero_q <= status.in_zero;
		end else if (cmd.gcd_en) begin
			if (status.gcd_done) begin
				g_q <= g_next;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (!diff_ab[W]) begin
				a_q <= diff_ab[W:1];
			end else begin
				b_q <= diff_ba[W:1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_n) begin
			qn_q <= quo_next;
		end
		if (cmd.div_init_n) begin
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= '0;
		end else if (cmd.div_init_d) begin
			rem_q <= '0;
			quo_q <= d_q;
			cnt_q <= '0;
		end else if (cmd.div_en) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign qn_ext = MW'(qn_q);
	assign qd_ext = MW'(quo_q);
	assign g_ext  = MW'(g_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_out   <= '0;
			denominator_out <= '0;
			gcd_value       <= '0;
			zero_error      <= 1'b0;
		end else if (cmd.out_load) begin
			if (zero_q) begin
				numerator_out   <= '0;
				denominator_out <= '0;
				gcd_value       <= '0;
				zero_error      <= 1'b1;
			end else begin
				numerator_out   <= qn_ext[FW-1:0];
				denominator_out <= qd_ext[FW-1:0];
				gcd_value       <= g_ext[FW-1:0];
				zero_error      <= 1'b0;
			end
		end
	end

endmodule

[sv/frred_ctrl.sv]
module frred_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  frred_pkg::status_t status,
	output frred_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_GCD   = 5'b00010,
		S_DIVN  = 5'b00100,
		S_DIVD  = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = status.in_zero ? S_WRITE : S_GCD;
				end
			end
			S_GCD: begin
				cmd.gcd_en = 1'b1;
				if (status.gcd_done) begin
					cmd.div_init_n = 1'b1;
					state_d        = S_DIVN;
				end
			end
			S_DIVN: begin
				cmd.div_en = 1'b1;
				if (status.div_last) begin
					cmd.save_n     = 1'b1;
					cmd.div_init_d = 1'b1;
					state_d        = S_DIVD;
				end
			end
			S_DIVD: begin
				cmd.div_en = 1'b1;
				if (status.div_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/fraction_reducer_core.sv]
// Fraction reducer: brings an unsigned fraction to lowest terms.
// Input channel: in_valid / in_stall with numerator_in and denominator_in.
// A word is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with numerator_out, denominator_out,
// gcd_value and zero_error; one output word for every input word.
// The gcd comes from a binary (shift and subtract) loop, one step a cycle,
// plus a final step that forms the gcd. One shared restoring divider,
// one quotient bit a cycle, then divides the numerator and the denominator
// in turn. Both inputs zero skip the gcd loop and the divider and report
// zero_error with all values zero.
// One word is worked on at a time; in_stall is high from acceptance until
// the result enters the output register. While out_stall holds a result,
// the next word is still computed and then waits inside the core.
// Reset (arst_n low, asynchronous) empties the core and the output register.
module fraction_reducer_core #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [frred_pkg::FIELD_W-1:0] numerator_in,
	input  logic [frred_pkg::FIELD_W-1:0] denominator_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [frred_pkg::FIELD_W-1:0] numerator_out,
	output logic [frred_pkg::FIELD_W-1:0] denominator_out,
	output logic [frred_pkg::FIELD_W-1:0] gcd_value,
	output logic                          zero_error
);

	frred_pkg::cmd_t    cmd;
	frred_pkg::status_t status;

	frred_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	frred_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.numerator_in    (numerator_in),
		.denominator_in  (denominator_in),
		.numerator_out   (numerator_out),
		.denominator_out (denominator_out),
		.gcd_value       (gcd_value),
		.zero_error      (zero_error)
	);

endmodule

[sv/frred_chk.sv]
`include "fraction_reducer_core_assert.svh"

module frred_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [frred_pkg::FIELD_W-1:0] numerator_out,
	input logic [frred_pkg::FIELD_W-1:0] denominator_out,
	input logic [frred_pkg::FIELD_W-1:0] gcd_value,
	input logic                          zero_error
);

	`FR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(numerator_out) && $stable(denominator_out) && $stable(gcd_value) && $stable(zero_error), "stalled output word changed")

	`FR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "core took a second word while busy")

	`FR_ASSERT(a_zero_word, out_valid && zero_error |-> numerator_out == '0 && denominator_out == '0 && gcd_value == '0, "zero error word carries nonzero values")

	`FR_ASSERT(a_gcd_nonzero, out_valid && !zero_error |-> gcd_value != '0, "gcd of a nonzero fraction is zero")

endmodule

bind fraction_reducer_core frred_chk u_frred_chk (.*);
